/* src/cartridge_bank_mapper_macros.svh */
// ----------------------------------------------------------------------------
// cartridge bank mapper assertion macros
// immediate-implication and next-cycle forms of a clocked, reset-gated check
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_MAPPER_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_MACROS_SVH

// same-cycle implication
`define CBM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/cbm_pkg.sv */
// ----------------------------------------------------------------------------
// cbm_pkg
// types and constants shared by the cartridge bank mapper modules
// ----------------------------------------------------------------------------
package cbm_pkg;

	localparam int ROM_BANK_W      = 9;
	localparam int RAM_BANK_W      = 4;
	localparam int SEL_W           = 4;
	localparam int ROM_OFS_W       = 14;
	localparam int RAM_OFS_W       = 13;
	localparam int ROM_ADDR_W      = ROM_BANK_W + ROM_OFS_W;
	localparam int RAM_ADDR_W      = RAM_BANK_W + RAM_OFS_W;
	localparam int CLOCK_REG_COUNT = 5;
	localparam int CLK_IDX_W       = $clog2(CLOCK_REG_COUNT);
	localparam int CFG_INDEX_W     = 2;
	localparam int CFG_DATA_W      = 4;

	localparam logic [ROM_BANK_W-1:0] ROM_BANK_INIT = 9'h001;
	localparam logic [SEL_W-1:0]      SEL_INIT      = 4'h1;
	localparam logic [ROM_BANK_W-1:0] ROM_HI_MASK   = 9'h060;
	localparam logic [ROM_BANK_W-1:0] ROM_LO_MASK   = 9'h01F;
	localparam logic [ROM_BANK_W-1:0] ROM_T3_MASK   = 9'h07F;
	localparam logic [3:0]            ENABLE_CODE   = 4'hA;
	localparam logic [SEL_W-1:0]      SEL_BANK_LAST = 4'h3;
	localparam logic [SEL_W-1:0]      SEL_CLK_FIRST = 4'h8;
	localparam logic [SEL_W-1:0]      SEL_CLK_LAST  = 4'hC;
	localparam int                    BANK_SEL_BIT  = 8;
	localparam logic [7:0]            DISABLED_READ = 8'hFF;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_MAPPER_KIND   = 2'd0,
		CFG_ROM_BANK_BITS = 2'd1,
		CFG_RAM_BANK_BITS = 2'd2
	} cfg_index_t;

	typedef enum logic {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		KIND_NONE  = 3'd0,
		KIND_TYPE1 = 3'd1,
		KIND_TYPE2 = 3'd2,
		KIND_TYPE3 = 3'd3,
		KIND_TYPE5 = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		TGT_ROM_READ  = 3'd0,
		TGT_RAM_READ  = 3'd1,
		TGT_RAM_WRITE = 3'd2,
		TGT_DIRECT    = 3'd3,
		TGT_NONE      = 3'd4
	} target_t;

	typedef struct packed {
		logic [2:0] mapper_kind;
		logic [3:0] rom_bank_bits;
		logic [2:0] ram_bank_bits;
	} cfg_t;

	typedef struct packed {
		logic [ROM_BANK_W-1:0] rom_bank;
		logic [SEL_W-1:0]      ram_select;
		logic                  ram_mode;
		logic                  ram_enabled;
		logic                  clock_enabled;
	} bank_state_t;

	typedef logic [CLOCK_REG_COUNT-1:0][7:0] clock_file_t;

	typedef struct packed {
		bank_state_t          nxt;
		logic                 clk_we;
		logic [CLK_IDX_W-1:0] clk_idx;
		logic [7:0]           clk_data;
	} bank_update_t;

	typedef struct packed {
		target_t               target;
		logic [ROM_ADDR_W-1:0] rom_address;
		logic [RAM_ADDR_W-1:0] ram_address;
		logic [7:0]            direct_value;
		logic [7:0]            ram_write_data;
	} result_t;

endpackage

/* src/cbm_xlate.sv */
// ----------------------------------------------------------------------------
// cbm_xlate
// decodes one bus access against the bank state: result and next state
// ----------------------------------------------------------------------------
module cbm_xlate (
	input  logic                  op,
	input  logic [15:0]           bus_address,
	input  logic [7:0]            write_value,
	input  cbm_pkg::cfg_t         cfg,
	input  cbm_pkg::bank_state_t  st,
	input  cbm_pkg::clock_file_t  clock_regs,
	output cbm_pkg::result_t      res,
	output cbm_pkg::bank_update_t upd
);
	import cbm_pkg::*;

	always_comb begin
		kind_t                 k;
		logic [3:0]            region;
		logic [3:0]            rom_bits_sat;
		logic [2:0]            ram_bits_sat;
		logic [ROM_BANK_W-1:0] rom_mask;
		logic [RAM_BANK_W-1:0] ram_mask;
		logic [RAM_BANK_W-1:0] ram_bank_sel;
		logic [RAM_BANK_W-1:0] ram_bank_win;
		logic                  sel_is_bank;
		logic                  sel_is_clk;
		logic                  ram_win;
		logic                  ram_wr;
		logic [7:0]            vv;
		logic [ROM_BANK_W-1:0] rb;

		k = (cfg.mapper_kind > 3'd4) ? KIND_NONE : kind_t'(cfg.mapper_kind);
		region = bus_address[15:12];
		rom_bits_sat = (cfg.rom_bank_bits > 4'(ROM_BANK_W)) ? 4'(ROM_BANK_W) : cfg.rom_bank_bits;
		ram_bits_sat = (cfg.ram_bank_bits > 3'(RAM_BANK_W)) ? 3'(RAM_BANK_W) : cfg.ram_bank_bits;
		for (int i = 0; i < ROM_BANK_W; i++) begin
			rom_mask[i] = (i < int'(rom_bits_sat));
		end
		for (int i = 0; i < RAM_BANK_W; i++) begin
			ram_mask[i] = (i < int'(ram_bits_sat));
		end
		sel_is_bank  = (st.ram_select <= SEL_BANK_LAST);
		sel_is_clk   = (st.ram_select >= SEL_CLK_FIRST) && (st.ram_select <= SEL_CLK_LAST);
		ram_bank_sel = st.ram_select & ram_mask;
		ram_bank_win = (k == KIND_TYPE1 && !st.ram_mode) ? '0 : ram_bank_sel;
		ram_win      = (bus_address[15:13] == 3'b101);
		ram_wr       = 1'b0;
		vv           = write_value;
		rb           = st.rom_bank;

		res          = '0;
		res.target   = TGT_NONE;
		upd.nxt      = st;
		upd.clk_we   = 1'b0;
		upd.clk_idx  = st.ram_select[CLK_IDX_W-1:0];
		upd.clk_data = write_value;

		if (op == OP_READ) begin
			if (region <= 4'h3) begin
				res.target      = TGT_ROM_READ;
				res.rom_address = ROM_ADDR_W'(bus_address[ROM_OFS_W-1:0]);
			end else if (region <= 4'h7) begin
				rb = st.rom_bank & rom_mask;
				if (k == KIND_TYPE1 && st.ram_mode) begin
					rb = rb & ROM_LO_MASK;
				end
				res.target      = TGT_ROM_READ;
				res.rom_address = {rb, bus_address[ROM_OFS_W-1:0]};
			end else if (ram_win) begin
				if (!st.ram_enabled) begin
					res.target       = TGT_DIRECT;
					res.direct_value = DISABLED_READ;
				end else if (k == KIND_TYPE3 && !sel_is_bank) begin
					res.target       = TGT_DIRECT;
					res.direct_value = sel_is_clk ? clock_regs[st.ram_select[CLK_IDX_W-1:0]] : 8'h00;
				end else begin
					res.target      = TGT_RAM_READ;
					res.ram_address = {ram_bank_win, bus_address[RAM_OFS_W-1:0]};
				end
			end else begin
				res.target = TGT_DIRECT;
			end
		end else begin
			if (region <= 4'h1) begin
				if (write_value[3:0] == ENABLE_CODE) begin
					upd.nxt.ram_enabled = 1'b1;
					if (k == KIND_TYPE3) begin
						upd.nxt.clock_enabled = 1'b1;
					end
				end else if (write_value == 8'h00) begin
					upd.nxt.ram_enabled   = 1'b0;
					upd.nxt.clock_enabled = 1'b0;
				end
			end else if (region <= 4'h3) begin
				if (write_value == 8'h00 && k != KIND_TYPE5) begin
					vv = 8'h01;
				end
				if (k == KIND_TYPE1 || (k == KIND_TYPE2 && bus_address[BANK_SEL_BIT])) begin
					rb = (st.rom_bank & ROM_HI_MASK) | ({1'b0, vv} & ROM_LO_MASK);
				end else if (k == KIND_TYPE3) begin
					rb = {1'b0, vv} & ROM_T3_MASK;
				end else if (k == KIND_TYPE5) begin
					if (region == 4'h2) begin
						rb = {st.rom_bank[ROM_BANK_W-1], vv};
					end else begin
						rb = {vv[0], st.rom_bank[7:0]};
					end
				end
				if (k == KIND_TYPE1 && (rb == 9'h020 || rb == 9'h040 || rb == 9'h060)) begin
					rb = rb + 9'd1;
				end
				upd.nxt.rom_bank = rb & rom_mask;
			end else if (region <= 4'h5) begin
				if (k == KIND_TYPE1) begin
					if (!st.ram_mode) begin
						rb = ((st.rom_bank & ROM_LO_MASK) | {2'b00, write_value[1:0], 5'b00000})
							& rom_mask;
					end else begin
						upd.nxt.ram_select = write_value[SEL_W-1:0] & ram_mask;
					end
					if (rb == 9'h020 || rb == 9'h040 || rb == 9'h060) begin
						rb = rb + 9'd1;
					end
					upd.nxt.rom_bank = rb;
				end else if (k == KIND_TYPE3) begin
					if (write_value <= 8'(SEL_BANK_LAST) ||
						(write_value >= 8'(SEL_CLK_FIRST) && write_value <= 8'(SEL_CLK_LAST))) begin
						upd.nxt.ram_select = write_value[SEL_W-1:0];
					end
				end else if (k == KIND_TYPE5) begin
					if (write_value[7:SEL_W] == '0) begin
						upd.nxt.ram_select = write_value[SEL_W-1:0];
					end
				end
			end else if (region <= 4'h7) begin
				if (k == KIND_TYPE1) begin
					if (write_value == 8'h00) begin
						upd.nxt.ram_mode = 1'b0;
					end else if (write_value == 8'h01) begin
						upd.nxt.ram_mode = 1'b1;
					end
				end
			end else if (ram_win) begin
				if (k == KIND_TYPE3) begin
					if (sel_is_bank && st.ram_enabled) begin
						ram_wr = 1'b1;
					end else if (sel_is_clk && st.clock_enabled) begin
						upd.clk_we = 1'b1;
					end
				end else if (st.ram_enabled) begin
					ram_wr = 1'b1;
				end
				if (ram_wr) begin
					res.target         = TGT_RAM_WRITE;
					res.ram_address    = {ram_bank_win, bus_address[RAM_OFS_W-1:0]};
					res.ram_write_data = write_value;
				end
			end
		end
	end

endmodule

/* src/cbm_state.sv */
// ----------------------------------------------------------------------------
// cbm_state
// bank registers, enable flags and clock registers, updated once per access
// ----------------------------------------------------------------------------
module cbm_state (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  cbm_pkg::bank_update_t upd,
	output cbm_pkg::bank_state_t  st,
	output cbm_pkg::clock_file_t  clock_regs
);
	import cbm_pkg::*;

	bank_state_t state_q;
	clock_file_t clock_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.rom_bank      <= ROM_BANK_INIT;
			state_q.ram_select    <= SEL_INIT;
			state_q.ram_mode      <= 1'b0;
			state_q.ram_enabled   <= 1'b0;
			state_q.clock_enabled <= 1'b0;
			clock_q               <= '0;
		end else if (step) begin
			state_q <= upd.nxt;
			if (upd.clk_we) begin
				clock_q[upd.clk_idx] <= upd.clk_data;
			end
		end
	end

	assign st         = state_q;
	assign clock_regs = clock_q;

endmodule

/* src/cartridge_bank_mapper.sv */
// ----------------------------------------------------------------------------
// cartridge_bank_mapper
// cartridge bank controller: CPU bus access in, flat ROM/RAM address out
// ----------------------------------------------------------------------------
// Takes one bus access per clock while the output side does not stall, and
// returns one result per access, in order. Each access passes an input
// register and an output register; a result shows on the outputs once it has
// moved into the output register, which waits while the output side stalls.
// The bank state is updated as the access moves into the output register, so
// the next access already sees the new bank. Sustained rate is one access per
// cycle, set by the single decode pass between the two registers. Configuration
// writes are taken at any time and must only be issued while no access is in
// flight.
module cartridge_bank_mapper (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cbm_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [cbm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                op,
	input  logic [15:0]                         bus_address,
	input  logic [7:0]                          write_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [2:0]                          target,
	output logic [cbm_pkg::ROM_ADDR_W-1:0]      rom_address,
	output logic [cbm_pkg::RAM_ADDR_W-1:0]      ram_address,
	output logic [7:0]                          direct_value,
	output logic [7:0]                          ram_write_data
);
	import cbm_pkg::*;

	cfg_t         cfg_q;
	logic         valid_s1;
	logic         op_s1;
	logic [15:0]  addr_s1;
	logic [7:0]   wdata_s1;
	logic         valid_s2;
	result_t      result_s2;
	logic         advance;
	bank_state_t  st;
	clock_file_t  clock_regs;
	result_t      res;
	bank_update_t upd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mapper_kind   <= 3'd0;
			cfg_q.rom_bank_bits <= 4'd1;
			cfg_q.ram_bank_bits <= 3'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MAPPER_KIND:   cfg_q.mapper_kind   <= cfg_data[2:0];
				CFG_ROM_BANK_BITS: cfg_q.rom_bank_bits <= cfg_data;
				CFG_RAM_BANK_BITS: cfg_q.ram_bank_bits <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1    <= op;
			addr_s1  <= bus_address;
			wdata_s1 <= write_value;
		end
	end

	cbm_xlate u_xlate (
		.op          (op_s1),
		.bus_address (addr_s1),
		.write_value (wdata_s1),
		.cfg         (cfg_q),
		.st          (st),
		.clock_regs  (clock_regs),
		.res         (res),
		.upd         (upd)
	);

	cbm_state u_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.upd        (upd),
		.st         (st),
		.clock_regs (clock_regs)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= res;
		end
	end

	assign out_valid      = valid_s2;
	assign target         = result_s2.target;
	assign rom_address    = result_s2.rom_address;
	assign ram_address    = result_s2.ram_address;
	assign direct_value   = result_s2.direct_value;
	assign ram_write_data = result_s2.ram_write_data;

endmodule

/* src/cbm_checker.sv */
// ----------------------------------------------------------------------------
// cbm_checker
// port-level checks of the cartridge bank mapper, bound to the top level
// ----------------------------------------------------------------------------
`include "cartridge_bank_mapper_macros.svh"

module cbm_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [2:0]                          target,
	input logic [cbm_pkg::ROM_ADDR_W-1:0]      rom_address,
	input logic [cbm_pkg::RAM_ADDR_W-1:0]      ram_address,
	input logic [7:0]                          direct_value,
	input logic [7:0]                          ram_write_data
);
	import cbm_pkg::*;

	logic stalled;
	logic not_rom;
	logic not_ram;
	logic not_ram_wr;

	assign stalled    = out_valid && !out_ready;
	assign not_rom    = out_valid && target != TGT_ROM_READ;
	assign not_ram    = out_valid && target != TGT_RAM_READ && target != TGT_RAM_WRITE;
	assign not_ram_wr = out_valid && target != TGT_RAM_WRITE;

	`CBM_ASSERT_NEXT(a_result_held, clk, arst_n, stalled, out_valid && $stable(target) && $stable(rom_address) && $stable(ram_address), "stalled result changed")
	`CBM_ASSERT_NOW(a_rom_addr_clear, clk, arst_n, not_rom, rom_address == '0, "rom address set on non-rom result")
	`CBM_ASSERT_NOW(a_ram_addr_clear, clk, arst_n, not_ram, ram_address == '0, "ram address set on non-ram result")
	`CBM_ASSERT_NOW(a_wr_data_clear, clk, arst_n, not_ram_wr, ram_write_data == 8'h00, "write data set on non-write result")
	`CBM_ASSERT_NOW(a_direct_clear, clk, arst_n, out_valid && target != TGT_DIRECT, direct_value == 8'h00, "direct value set on non-direct result")

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (.*);
